@@ rtl/tga_rle_pkg.sv @@
// Shared constants and widths for the TGA run-length pixel decoder.
package tga_rle_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned BPP_W       = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RLE_MODE        = 2'd0,
    CFG_BYTES_PER_PIXEL = 2'd1,
    CFG_PIXEL_TOTAL     = 2'd2
  } cfg_index_t;

  localparam logic [BYTE_W-1:0] RUN_FLAG_LIMIT = 8'd128;
  localparam logic [BYTE_W-1:0] RUN_BIAS       = 8'd127;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE   = 8'hFF;
  localparam logic [BPP_W-1:0]  BPP_WITH_ALPHA = 3'd4;
  localparam logic [BPP_W-1:0]  BPP_RESET      = 3'd3;

endpackage

@@ rtl/tga_rle_pixel_decoder.sv @@
// Top level of the TGA run-length pixel decoder.
//
// Image data bytes enter on data_byte with in_valid/in_stall, one word per
// cycle. A word is taken at a clock edge where in_valid is high and in_stall
// is low. Decoded pixels leave on red/green/blue/alpha with a repeat count,
// image_done and status, under out_valid/out_stall.
// Each byte is handled in the cycle it is accepted: the state registers are
// loaded at that edge, and a finished pixel goes to the output register or,
// while it stalls, to the skid buffer. One byte is taken every cycle while in_stall is low.
// The output register is backed by a one-word skid buffer, so input words
// keep flowing while a finished pixel waits; in_stall rises only when the
// skid buffer is also full, and is driven straight from a flop.
// Reset (rst, synchronous) sets rle_mode to 1, bytes_per_pixel to 3 and
// pixel_total to 1, and empties both output stages. A write to one of the
// three configuration registers restarts decoding with the register values
// kept. Once the image is complete, further bytes are accepted and dropped.
module tga_rle_pixel_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tga_rle_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [tga_rle_pkg::BYTE_W-1:0]       data_byte,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  output logic [tga_rle_pkg::BYTE_W-1:0]       red,
  output logic [tga_rle_pkg::BYTE_W-1:0]       green,
  output logic [tga_rle_pkg::BYTE_W-1:0]       blue,
  output logic [tga_rle_pkg::BYTE_W-1:0]       alpha,
  output logic [tga_rle_pkg::BYTE_W-1:0]       repeat_res,
  output logic                                 image_done,
  output logic                                 status,
  output logic                                 out_valid,
  input  logic                                 out_stall
);
  import tga_rle_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] repeat_res;
    logic              image_done;
    logic              status;
  } pixel_t;

  // Configuration registers.
  logic                rle_mode;
  logic [BPP_W-1:0]    bytes_per_pixel;
  logic [COUNT_W-1:0]  pixel_total;

  // Decoder state. pixels_left counts down from pixel_total; zero means halted.
  logic                expect_header;
  logic                packet_is_run;
  logic [BYTE_W-1:0]   packet_pixels_left;
  logic [1:0]          byte_in_pixel;
  logic [3*BYTE_W-1:0] colour_bytes;
  logic [COUNT_W-1:0]  pixels_left;

  logic                expect_header_next;
  logic                packet_is_run_next;
  logic [BYTE_W-1:0]   packet_pixels_left_next;
  logic [1:0]          byte_in_pixel_next;
  logic [3*BYTE_W-1:0] colour_bytes_next;
  logic [COUNT_W-1:0]  pixels_left_next;

  // Output register and skid stage.
  pixel_t out_word;
  pixel_t skid_word;
  logic   skid_valid;

  pixel_t res;
  logic   res_valid;

  logic   accept;
  logic   active;
  logic   in_header;
  logic   size4;
  logic   last_byte;
  logic   rem_small;
  logic   rem_one;
  logic   run_clip;
  logic   run_done;
  logic   out_free;
  logic   cfg_hit;
  logic   rle_mode_cfg;
  logic [COUNT_W-1:0] pixel_total_cfg;

  assign accept    = in_valid && !in_stall;
  assign active    = (pixels_left != '0);
  assign in_header = rle_mode && expect_header;
  assign size4     = (bytes_per_pixel == BPP_WITH_ALPHA);
  assign last_byte = size4 ? (byte_in_pixel == 2'd3) : (byte_in_pixel == 2'd2);
  assign rem_small = (pixels_left[COUNT_W-1:BYTE_W] == '0);
  assign rem_one   = (pixels_left == COUNT_W'(1));
  assign run_clip  = rem_small && (packet_pixels_left > pixels_left[BYTE_W-1:0]);
  assign run_done  = rem_small && (packet_pixels_left >= pixels_left[BYTE_W-1:0]);

  always_comb begin
    expect_header_next      = expect_header;
    packet_is_run_next      = packet_is_run;
    packet_pixels_left_next = packet_pixels_left;
    byte_in_pixel_next      = byte_in_pixel;
    colour_bytes_next       = colour_bytes;
    pixels_left_next        = pixels_left;
    res_valid               = 1'b0;

    case (byte_in_pixel)
      2'd0: colour_bytes_next[BYTE_W-1:0]          = data_byte;
      2'd1: colour_bytes_next[2*BYTE_W-1:BYTE_W]   = data_byte;
      2'd2: colour_bytes_next[3*BYTE_W-1:2*BYTE_W] = data_byte;
      default: colour_bytes_next = colour_bytes;
    endcase

    res.red        = colour_bytes_next[3*BYTE_W-1:2*BYTE_W];
    res.green      = colour_bytes_next[2*BYTE_W-1:BYTE_W];
    res.blue       = colour_bytes_next[BYTE_W-1:0];
    res.alpha      = size4 ? data_byte : ALPHA_OPAQUE;
    res.repeat_res = BYTE_W'(1);
    res.image_done = rem_one;
    res.status     = 1'b0;

    if (in_header) begin
      // Packet header: below 128 is a raw packet, else a run.
      colour_bytes_next  = colour_bytes;
      expect_header_next = 1'b0;
      byte_in_pixel_next = 2'd0;
      if (data_byte < RUN_FLAG_LIMIT) begin
        packet_is_run_next      = 1'b0;
        packet_pixels_left_next = data_byte + BYTE_W'(1);
      end else begin
        packet_is_run_next      = 1'b1;
        packet_pixels_left_next = data_byte - RUN_BIAS;
      end
    end else if (!last_byte) begin
      byte_in_pixel_next = byte_in_pixel + 2'd1;
    end else begin
      byte_in_pixel_next = 2'd0;
      res_valid          = 1'b1;
      if (rle_mode && packet_is_run) begin
        res.repeat_res          = run_clip ? pixels_left[BYTE_W-1:0] : packet_pixels_left;
        res.status              = run_clip;
        res.image_done          = run_done;
        packet_pixels_left_next = '0;
        expect_header_next      = 1'b1;
      end else if (rle_mode) begin
        packet_pixels_left_next = packet_pixels_left - BYTE_W'(1);
        if (packet_pixels_left_next == '0) begin
          expect_header_next = 1'b1;
        end else begin
          res.status = rem_one;
        end
      end
      pixels_left_next = pixels_left - COUNT_W'(res.repeat_res);
    end
  end

  assign cfg_hit = cfg_we && ((cfg_index == CFG_RLE_MODE) ||
                              (cfg_index == CFG_BYTES_PER_PIXEL) ||
                              (cfg_index == CFG_PIXEL_TOTAL));
  assign rle_mode_cfg    = (cfg_index == CFG_RLE_MODE) ? cfg_data[0] : rle_mode;
  assign pixel_total_cfg = (cfg_index == CFG_PIXEL_TOTAL) ? cfg_data : pixel_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode           <= 1'b1;
      bytes_per_pixel    <= BPP_RESET;
      pixel_total        <= COUNT_W'(1);
      expect_header      <= 1'b1;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= '0;
      byte_in_pixel      <= 2'd0;
      colour_bytes       <= '0;
      pixels_left        <= COUNT_W'(1);
    end else if (cfg_hit) begin
      case (cfg_index)
        CFG_RLE_MODE:        rle_mode        <= cfg_data[0];
        CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        CFG_PIXEL_TOTAL:     pixel_total     <= cfg_data;
        default:             rle_mode        <= rle_mode;
      endcase
      expect_header      <= rle_mode_cfg;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= '0;
      byte_in_pixel      <= 2'd0;
      colour_bytes       <= '0;
      pixels_left        <= pixel_total_cfg;
    end else if (accept && active) begin
      expect_header      <= expect_header_next;
      packet_is_run      <= packet_is_run_next;
      packet_pixels_left <= packet_pixels_left_next;
      byte_in_pixel      <= byte_in_pixel_next;
      colour_bytes       <= colour_bytes_next;
      pixels_left        <= pixels_left_next;
    end
  end

  // A new pixel goes to the output register when it is free, else to the skid.
  logic new_pixel;
  assign new_pixel = accept && active && !cfg_hit && res_valid;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || new_pixel;
      skid_valid <= 1'b0;
    end else if (new_pixel) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : res;
    end
    if (!out_free && new_pixel) begin
      skid_word <= res;
    end
  end

  assign in_stall   = skid_valid;
  assign red        = out_word.red;
  assign green      = out_word.green;
  assign blue       = out_word.blue;
  assign alpha      = out_word.alpha;
  assign repeat_res = out_word.repeat_res;
  assign image_done = out_word.image_done;
  assign status     = out_word.status;

endmodule

@@ rtl/tga_rle_checker.sv @@
// Port-level checks for the TGA run-length pixel decoder, bound to its top level.
module tga_rle_checker (
  input logic                           clk,
  input logic                           rst,
  input logic [tga_rle_pkg::BYTE_W-1:0] red,
  input logic [tga_rle_pkg::BYTE_W-1:0] green,
  input logic [tga_rle_pkg::BYTE_W-1:0] blue,
  input logic [tga_rle_pkg::BYTE_W-1:0] alpha,
  input logic [tga_rle_pkg::BYTE_W-1:0] repeat_res,
  input logic                           image_done,
  input logic                           status,
  input logic                           out_valid,
  input logic                           out_stall
);
  import tga_rle_pkg::*;

  // A stalled word must stay put.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(red) && $stable(green) && $stable(blue) &&
      $stable(alpha) && $stable(repeat_res) && $stable(image_done) && $stable(status))
    else $error("output word changed while stalled");

  // An overrun is only ever reported on the pixel that ends the image.
  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> image_done && (repeat_res != '0))
    else $error("overrun reported without image_done or with zero repeat");

  // Nothing follows the last pixel of an image.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && image_done |=> !out_valid)
    else $error("pixel emitted after image completed");

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_tga_rle_checker (
  .clk        (clk),
  .rst        (rst),
  .red        (red),
  .green      (green),
  .blue       (blue),
  .alpha      (alpha),
  .repeat_res (repeat_res),
  .image_done (image_done),
  .status     (status),
  .out_valid  (out_valid),
  .out_stall  (out_stall)
);

@@ sim/tga_pixel_checker.sv @@
// Checker for the TGA pixel decoder: tracks the decode state, predicts pixels, compares them.
`timescale 1ns / 1ps

module tga_pixel_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [tga_rle_pkg::BYTE_W-1:0]      data_byte,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [tga_rle_pkg::BYTE_W-1:0]      red,
  input  logic [tga_rle_pkg::BYTE_W-1:0]      green,
  input  logic [tga_rle_pkg::BYTE_W-1:0]      blue,
  input  logic [tga_rle_pkg::BYTE_W-1:0]      alpha,
  input  logic [tga_rle_pkg::BYTE_W-1:0]      repeat_res,
  input  logic                                image_done,
  input  logic                                status,
  input  logic                                out_valid,
  input  logic                                out_stall,
  output int                                  fail_count,
  output int                                  outstanding,
  output int                                  live_bytes
);
  import tga_rle_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] count;
    logic              done;
    logic              status;
  } pixel_t;

  // Configuration copy.
  logic              rle_on;
  logic [BPP_W-1:0]  pixel_bytes_cfg;
  logic [COUNT_W-1:0] image_pixels;

  // Decode state.
  logic               want_header;
  logic               in_run;
  logic [BYTE_W-1:0]  packet_left;
  logic [1:0]         byte_pos;
  logic [23:0]        colour_acc;
  logic [COUNT_W-1:0] pixels_emitted;
  logic               stopped;

  pixel_t expected_pixels[$];
  int     failures = 0;
  int     decoded_bytes = 0;

  task automatic restart_decode();
    want_header    = rle_on;
    in_run         = 1'b0;
    packet_left    = '0;
    byte_pos       = '0;
    colour_acc     = '0;
    pixels_emitted = '0;
    stopped        = 1'b0;
  endtask

  task automatic apply_config(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_RLE_MODE: begin
        rle_on = value[0];
        restart_decode();
      end
      CFG_BYTES_PER_PIXEL: begin
        pixel_bytes_cfg = value[BPP_W-1:0];
        restart_decode();
      end
      CFG_PIXEL_TOTAL: begin
        image_pixels = value[COUNT_W-1:0];
        restart_decode();
      end
      default: ;  // Unknown index: no register, no restart.
    endcase
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b, output bit produced,
                             output pixel_t px);
    logic [2:0]         size;
    logic [COUNT_W-1:0] remaining;
    logic [COUNT_W-1:0] reps;
    logic               overflow;
    produced = 1'b0;
    px       = '0;
    size     = (pixel_bytes_cfg == BPP_WITH_ALPHA) ? 3'd4 : 3'd3;
    if (stopped || pixels_emitted >= image_pixels) return;
    decoded_bytes++;

    if (rle_on && want_header) begin
      if (b < RUN_FLAG_LIMIT) begin
        in_run      = 1'b0;
        packet_left = b + 8'd1;
      end else begin
        in_run      = 1'b1;
        packet_left = b - RUN_BIAS;
      end
      want_header = 1'b0;
      byte_pos    = '0;
      return;
    end

    if (byte_pos < 3) colour_acc[byte_pos*8 +: 8] = b;
    if (byte_pos + 1 < size) begin
      byte_pos = byte_pos + 2'd1;
      return;
    end
    byte_pos = '0;

    remaining = image_pixels - pixels_emitted;
    reps      = 1;
    overflow  = 1'b0;
    if (rle_on) begin
      if (in_run) begin
        reps = packet_left;
        if (reps > remaining) begin
          reps     = remaining;
          overflow = 1'b1;
        end
        packet_left = '0;
        want_header = 1'b1;
      end else begin
        packet_left = packet_left - 8'd1;
        if (packet_left == 0) want_header = 1'b1;
        else if (remaining == 1) overflow = 1'b1;
      end
    end

    pixels_emitted = pixels_emitted + reps;
    px.done = 1'b0;
    if (pixels_emitted >= image_pixels) begin
      px.done = 1'b1;
      stopped = 1'b1;
    end
    // Stored order is B, G, R; the output swaps the first and third bytes.
    px.red    = colour_acc[23:16];
    px.green  = colour_acc[15:8];
    px.blue   = colour_acc[7:0];
    px.alpha  = (size == 3'd4) ? b : ALPHA_OPAQUE;
    px.count  = reps[BYTE_W-1:0];
    px.status = overflow;
    produced  = 1'b1;
  endtask

  task automatic check_field(input string what, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      failures++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    pixel_t fresh;
    pixel_t oldest;
    bit     produced;
    if (rst) begin
      rle_on          = 1'b1;
      pixel_bytes_cfg = BPP_RESET;
      image_pixels    = 1;
      restart_decode();
      expected_pixels.delete();
    end else begin
      // A pixel leaving now was made by an earlier word, so compare first.
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          failures++;
          $display("%0t: unexpected pixel: expected none, actual r=%0d g=%0d b=%0d a=%0d",
                   $time, red, green, blue, alpha);
        end else begin
          oldest = expected_pixels.pop_front();
          check_field("red", oldest.red, red);
          check_field("green", oldest.green, green);
          check_field("blue", oldest.blue, blue);
          check_field("alpha", oldest.alpha, alpha);
          check_field("repeat_res", oldest.count, repeat_res);
          check_field("image_done", BYTE_W'(oldest.done), BYTE_W'(image_done));
          check_field("status", BYTE_W'(oldest.status), BYTE_W'(status));
        end
      end
      if (cfg_we) apply_config(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        decode_byte(data_byte, produced, fresh);
        if (produced) expected_pixels.push_back(fresh);
      end
    end
    fail_count  <= failures;
    outstanding <= expected_pixels.size();
    live_bytes  <= decoded_bytes;
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the TGA pixel decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tga_rle_pkg::*;

  localparam int RANDOM_ITEMS    = 900;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYCLE_LIMIT     = 500000;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic [BYTE_W-1:0]      data_byte;
  logic                   in_valid;
  logic                   in_stall;
  logic [BYTE_W-1:0]      red;
  logic [BYTE_W-1:0]      green;
  logic [BYTE_W-1:0]      blue;
  logic [BYTE_W-1:0]      alpha;
  logic [BYTE_W-1:0]      repeat_res;
  logic                   image_done;
  logic                   status;
  logic                   out_valid;
  logic                   out_stall;

  int fail_count;
  int outstanding;
  int live_bytes;
  int cycle_count = 0;

  bit steady_send = 1'b0;
  bit steady_recv = 1'b0;
  bit squeeze = 1'b0;
  bit squeeze_done = 1'b0;

  logic       cur_rle;
  int         cur_size;
  logic [7:0] phase_bytes[$];

  tga_rle_pixel_decoder dut (.*);
  tga_pixel_checker checker_i (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int unsigned r;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else if (steady_recv) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 30)) @(posedge clk);
        end
      end
    end
  end

  function automatic int sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_send || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    data_byte <= b;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_phase(input int first, input int last);
    for (int i = first; i < last; i++) send_byte(phase_bytes[i]);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper bits of the narrow registers carry random junk when junk is set.
  task automatic apply_settings(input logic rle, input logic [BPP_W-1:0] bpp,
                                input logic [31:0] total, input bit junk);
    logic [CFG_DATA_W-1:0] noise;
    noise = junk ? $urandom : '0;
    settle();
    write_reg(CFG_RLE_MODE, {noise[CFG_DATA_W-1:1], rle});
    write_reg(CFG_BYTES_PER_PIXEL, {noise[CFG_DATA_W-1:BPP_W], bpp});
    write_reg(CFG_PIXEL_TOTAL, total);
    cur_rle  = rle;
    cur_size = (bpp == BPP_WITH_ALPHA) ? 4 : 3;
  endtask

  task automatic push_pixel();
    repeat (cur_size) phase_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed packets with random colours, some loose noise bytes; plain mode gets random bytes only.
  task automatic build_bytes(input int target);
    int unsigned r;
    int          count;
    while (phase_bytes.size() < target) begin
      r = $urandom_range(0, 99);
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
      if (!cur_rle) begin
        phase_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 45) begin
        phase_bytes.push_back(8'(127 + count));
        push_pixel();
      end else if (r < 90) begin
        phase_bytes.push_back(8'(count - 1));
        repeat (count) push_pixel();
      end else begin
        repeat ($urandom_range(1, 5)) phase_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_phase();
    int unsigned r;
    logic        rle;
    logic [2:0]  bpp;
    logic [31:0] total;
    int          half;
    rle = ($urandom_range(0, 4) != 0);
    r = $urandom_range(0, 9);
    bpp = (r < 4) ? 3'd3 : (r < 8) ? BPP_WITH_ALPHA : 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 10) total = 32'hFFFF_FFFF;
    else if (r < 14) total = 32'd0;
    else if (r < 22) total = $urandom;
    else total = $urandom_range(1, 300);
    apply_settings(rle, bpp, total, 1'b1);
    steady_send = ($urandom_range(0, 4) == 0);
    steady_recv = ($urandom_range(0, 4) == 0);
    phase_bytes.delete();
    build_bytes($urandom_range(40, 160));
    if ($urandom_range(0, 5) == 0) begin
      // A write to an index with no register must leave decoding where it was.
      half = phase_bytes.size() / 2;
      send_phase(0, half);
      settle();
      write_reg(CFG_UNUSED_INDEX, $urandom);
      send_phase(half, phase_bytes.size());
    end else begin
      send_phase(0, phase_bytes.size());
    end
  endtask

  initial begin
    int start_live;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_RLE_MODE;
    cfg_data  <= '0;
    data_byte <= '0;
    in_valid  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, one-pixel image: a raw packet longer than the image.
    phase_bytes = '{8'h05, 8'h11, 8'h22, 8'h33, 8'h44};
    send_phase(0, phase_bytes.size());

    // One-pixel raw packet, then a full-length run clipped at the image end.
    apply_settings(1'b1, 3'd3, 32'd20, 1'b0);
    phase_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_phase(0, phase_bytes.size());

    // Four bytes per word: a single-copy run, then a 128-pixel raw packet cut short.
    apply_settings(1'b1, BPP_WITH_ALPHA, 32'd2, 1'b0);
    phase_bytes = '{8'h80, 8'h01, 8'h02, 8'h03, 8'h04,
                    8'h7F, 8'hFF, 8'hFE, 8'hFD, 8'hFC};
    send_phase(0, phase_bytes.size());

    // Plain mode with an odd pixel size; the byte after the image is dropped.
    apply_settings(1'b0, 3'd7, 32'd1, 1'b0);
    phase_bytes = '{8'hA5, 8'h5A, 8'hC3, 8'h3C};
    send_phase(0, phase_bytes.size());

    // Empty image drops everything.
    apply_settings(1'b1, 3'd3, 32'd0, 1'b0);
    phase_bytes = '{8'h81};
    send_phase(0, phase_bytes.size());

    settle();
    start_live = live_bytes;

    // Long receiver hold-off while the sender keeps offering words.
    apply_settings(1'b0, 3'd3, 32'hFFFF_FFFF, 1'b0);
    steady_send = 1'b1;
    steady_recv = 1'b0;
    phase_bytes.delete();
    build_bytes(300);
    squeeze = 1'b1;
    send_phase(0, phase_bytes.size());

    while (live_bytes - start_live < RANDOM_ITEMS) random_phase();

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
